### sv/lmst_pkg.sv
// Package for the logger mode and sample timer.
// Holds the payload structs, event and mode codes, register indexes and constants.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package lmst_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] HOLD_STEP    = 16'd4;
    localparam logic [3:0]  ERR_MAX      = 4'd15;

    localparam logic [14:0] RST_SAMPLE_INTERVAL = 15'd600;
    localparam logic [15:0] RST_IDLE_LIMIT      = 16'd1600;
    localparam logic [7:0]  RST_WAIT_LIMIT      = 8'd30;
    localparam logic [15:0] RST_HOLD_RELOAD     = 16'd5000;
    localparam logic [7:0]  RST_STARTUP_WINDOW  = 8'd5;

    typedef enum logic [2:0] {
        OP_SEC_TICK   = 3'd0,
        OP_MS_TICK    = 3'd1,
        OP_RED_EDGE   = 3'd2,
        OP_GREEN_EDGE = 3'd3,
        OP_SAMPLE_DONE = 3'd4,
        OP_CFG_CMD    = 3'd5,
        OP_SENSOR_SILENT = 3'd6,
        OP_SENSOR_OK  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        MODE_STD = 2'd0,
        MODE_MTN = 2'd1,
        MODE_ECO = 2'd2,
        MODE_CFG = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_INTERVAL = 3'd0,
        CFG_IDLE_LIMIT      = 3'd1,
        CFG_WAIT_LIMIT      = 3'd2,
        CFG_HOLD_RELOAD     = 3'd3,
        CFG_STARTUP_WINDOW  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] op;
        logic       red_down;
        logic       green_down;
    } t_in_item;

    typedef struct packed {
        logic [1:0] mode_now;
        logic       sample_due;
        logic       read_gps;
        logic       store_sample;
        logic       sensor_waiting;
        logic [3:0] sensor_errors;
    } t_out_item;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

### sv/lmst_core.sv
// State and event logic of the logger mode and sample timer.
// Holds the configuration registers and all timer state; computes one result per event.
// Depends on lmst_pkg.
`timescale 1ns / 1ps

module lmst_core
    import lmst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [14:0] r_sample_interval;
    logic [15:0] r_idle_limit;
    logic [7:0]  r_wait_limit;
    logic [15:0] r_hold_reload;

    t_mode       r_mode,       n_mode;
    logic [15:0] r_sample_cd,  n_sample_cd;
    logic        r_sample_flag, n_sample_flag;
    logic [15:0] r_idle_cd,    n_idle_cd;
    logic [7:0]  r_boot_cd,    n_boot_cd;
    logic [15:0] r_hold_cd,    n_hold_cd;
    logic        r_hold_armed, n_hold_armed;
    logic        r_red_latch,  n_red_latch;
    logic        r_green_latch, n_green_latch;
    logic        r_gps_skip,   n_gps_skip;
    logic        r_wait_flag,  n_wait_flag;
    logic [7:0]  r_wait_cd,    n_wait_cd;
    logic [3:0]  r_err_cnt,    n_err_cnt;
    logic        gps_out;
    logic        store_out;

    always_comb begin
        t_mode m;
        m             = r_mode;
        n_mode        = r_mode;
        n_sample_cd   = r_sample_cd;
        n_sample_flag = r_sample_flag;
        n_idle_cd     = r_idle_cd;
        n_boot_cd     = r_boot_cd;
        n_hold_cd     = r_hold_cd;
        n_hold_armed  = r_hold_armed;
        n_red_latch   = r_red_latch;
        n_green_latch = r_green_latch;
        n_gps_skip    = r_gps_skip;
        n_wait_flag   = r_wait_flag;
        n_wait_cd     = r_wait_cd;
        n_err_cnt     = r_err_cnt;
        gps_out       = 1'b0;
        store_out     = 1'b0;

        unique case (t_op'(i_item.op))
            OP_SEC_TICK: begin
                if (r_sample_cd != 16'd0) begin
                    n_sample_cd = r_sample_cd - 16'd1;
                    if (r_sample_cd == 16'd1) begin
                        n_sample_flag = 1'b1;
                    end
                end
                // Leaving config never comes from eco, so no sample reload here.
                if (r_mode == MODE_CFG && r_idle_cd != 16'd0) begin
                    n_idle_cd = r_idle_cd - 16'd1;
                    if (r_idle_cd == 16'd1) begin
                        n_mode = MODE_STD;
                    end
                end
                if (r_boot_cd != 8'd0) begin
                    n_boot_cd = r_boot_cd - 8'd1;
                end
                if (r_wait_flag) begin
                    if (r_wait_cd != 8'd0) begin
                        n_wait_cd = r_wait_cd - 8'd1;
                    end else begin
                        n_wait_flag = 1'b0;
                        if (r_err_cnt < ERR_MAX) begin
                            n_err_cnt = r_err_cnt + 4'd1;
                        end
                    end
                end
            end
            OP_MS_TICK: begin
                if (r_hold_armed) begin
                    if (r_hold_cd <= HOLD_STEP) begin
                        n_hold_cd = r_hold_reload;
                        // Red acts first; green then sees the mode red left.
                        if (i_item.red_down) begin
                            m = (m != MODE_MTN) ? MODE_MTN : MODE_STD;
                        end
                        if (i_item.green_down) begin
                            if (m != MODE_ECO) begin
                                m           = MODE_ECO;
                                n_sample_cd = {r_sample_interval, 1'b0};
                            end else begin
                                m           = MODE_STD;
                                n_sample_cd = {1'b0, r_sample_interval};
                            end
                        end
                        n_mode = m;
                    end else begin
                        n_hold_cd = r_hold_cd - HOLD_STEP;
                    end
                    if (r_boot_cd != 8'd0 && i_item.red_down) begin
                        n_mode    = MODE_CFG;
                        n_idle_cd = r_idle_limit;
                    end
                end
            end
            OP_RED_EDGE: begin
                if (!r_red_latch) begin
                    n_red_latch  = 1'b1;
                    n_hold_cd    = r_hold_reload;
                    n_hold_armed = 1'b1;
                end else begin
                    n_red_latch  = 1'b0;
                    n_hold_armed = 1'b0;
                end
            end
            OP_GREEN_EDGE: begin
                if (!r_green_latch) begin
                    n_green_latch = 1'b1;
                    n_hold_cd     = r_hold_reload;
                    n_hold_armed  = 1'b1;
                end else begin
                    n_green_latch = 1'b0;
                    n_hold_armed  = 1'b0;
                end
            end
            OP_SAMPLE_DONE: begin
                if (r_sample_flag) begin
                    if (r_mode == MODE_ECO) begin
                        gps_out     = ~r_gps_skip;
                        n_gps_skip  = ~r_gps_skip;
                        n_sample_cd = {r_sample_interval, 1'b0};
                    end else begin
                        gps_out     = 1'b1;
                        n_sample_cd = {1'b0, r_sample_interval};
                    end
                    store_out     = (r_mode != MODE_MTN);
                    n_err_cnt     = 4'd0;
                    n_sample_flag = 1'b0;
                end
            end
            OP_CFG_CMD: begin
                if (r_mode == MODE_CFG) begin
                    n_idle_cd = r_idle_limit;
                end
            end
            OP_SENSOR_SILENT: begin
                if (!r_wait_flag) begin
                    n_wait_flag = 1'b1;
                    n_wait_cd   = r_wait_limit;
                end
            end
            OP_SENSOR_OK: begin
                n_wait_flag = 1'b0;
                n_wait_cd   = 8'd0;
            end
            default: begin
            end
        endcase
    end

    assign o_result.mode_now       = n_mode;
    assign o_result.sample_due     = n_sample_flag;
    assign o_result.read_gps       = gps_out;
    assign o_result.store_sample   = store_out;
    assign o_result.sensor_waiting = n_wait_flag;
    assign o_result.sensor_errors  = n_err_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_interval <= RST_SAMPLE_INTERVAL;
            r_idle_limit      <= RST_IDLE_LIMIT;
            r_wait_limit      <= RST_WAIT_LIMIT;
            r_hold_reload     <= RST_HOLD_RELOAD;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_SAMPLE_INTERVAL: r_sample_interval <= i_cfg.data[14:0];
                CFG_IDLE_LIMIT:      r_idle_limit      <= i_cfg.data;
                CFG_WAIT_LIMIT:      r_wait_limit      <= i_cfg.data[7:0];
                CFG_HOLD_RELOAD:     r_hold_reload     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_STD;
            r_sample_cd   <= {1'b0, RST_SAMPLE_INTERVAL};
            r_sample_flag <= 1'b0;
            r_idle_cd     <= RST_IDLE_LIMIT;
            r_boot_cd     <= RST_STARTUP_WINDOW;
            r_hold_cd     <= RST_HOLD_RELOAD;
            r_hold_armed  <= 1'b0;
            r_red_latch   <= 1'b0;
            r_green_latch <= 1'b0;
            r_gps_skip    <= 1'b0;
            r_wait_flag   <= 1'b0;
            r_wait_cd     <= 8'd0;
            r_err_cnt     <= 4'd0;
        end else begin
            if (i_fire) begin
                r_mode        <= n_mode;
                r_sample_cd   <= n_sample_cd;
                r_sample_flag <= n_sample_flag;
                r_idle_cd     <= n_idle_cd;
                r_hold_cd     <= n_hold_cd;
                r_hold_armed  <= n_hold_armed;
                r_red_latch   <= n_red_latch;
                r_green_latch <= n_green_latch;
                r_gps_skip    <= n_gps_skip;
                r_wait_flag   <= n_wait_flag;
                r_wait_cd     <= n_wait_cd;
                r_err_cnt     <= n_err_cnt;
            end
            // Writing the startup window also restarts the boot countdown.
            if (i_cfg.we && i_cfg.idx == CFG_STARTUP_WINDOW) begin
                r_boot_cd <= i_cfg.data[7:0];
            end else if (i_fire) begin
                r_boot_cd <= n_boot_cd;
            end
        end
    end

endmodule

### sv/lmst_out_reg.sv
// Result register of the logger mode and sample timer.
// Holds one finished result and loads the next one as the current one leaves.
// Depends on lmst_pkg.
`timescale 1ns / 1ps

module lmst_out_reg
    import lmst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load_valid,
    output logic      o_load_ready,
    input  t_out_item i_load_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_valid;
    t_out_item r_data;

    assign o_load_ready = !r_valid || i_out_ready;
    assign o_out_valid  = r_valid;
    assign o_out_data   = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ready) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ready && i_load_valid) begin
            r_data <= i_load_data;
        end
    end

endmodule

### sv/logger_mode_and_sample_timer.sv
// Top level of the logger mode and sample timer.
// Input register, event core (lmst_core) and result register (lmst_out_reg).
// Depends on lmst_pkg, lmst_core and lmst_out_reg.
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+--------------------------
//  in       | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready| o_out_data (t_out_item)
//  cfg      | input     | i_cfg_we (no wait)       | i_cfg_idx, i_cfg_data
//
// Every event gives one result; its transaction passes through the input register
// and then the result register; the event core in between is combinational.
// One event is accepted per cycle unless the output stalls.
// A stalled output holds both stages, and the input takes a new transaction
// as soon as the result register frees a slot.
// Synchronous active-low reset restores non-data registers to documented values.
`timescale 1ns / 1ps

module logger_mode_and_sample_timer
    import lmst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      load_ready;
    logic      advance;
    t_out_item core_result;
    t_cfg_wr   cfg_wr;

    assign advance    = r_in_valid && load_ready;
    assign o_in_ready = !r_in_valid || load_ready;

    assign cfg_wr.we   = i_cfg_we;
    assign cfg_wr.idx  = i_cfg_idx;
    assign cfg_wr.data = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    lmst_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_fire   (advance),
        .i_item   (r_in_data),
        .o_result (core_result)
    );

    lmst_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_in_valid),
        .o_load_ready (load_ready),
        .i_load_data  (core_result),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    // A completed sample clears its own request and the error count.
    a_done_clears_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.read_gps || o_out_data.store_sample))
            |-> (!o_out_data.sample_due))
        else $error("sample done left the request pending");

    a_store_not_maint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.store_sample)
            |-> (o_out_data.mode_now != MODE_MTN && o_out_data.sensor_errors == 4'd0))
        else $error("sample stored in maintenance or with errors kept");

    // A full input stage behind a stalled result must hold off new transactions.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while both stages are full and stalled");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("advanced event did not reach the result register");

endmodule

### verif/logger_mode_and_sample_timer_tb.sv
// Self-checking testbench for the logger mode and sample timer.
// Drives random and directed events, predicts each status word and compares it.
// Depends on lmst_pkg and logger_mode_and_sample_timer.
`timescale 1ns / 1ps

module logger_mode_and_sample_timer_tb;
    import lmst_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 80;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;

    // Events waiting to be driven and status words waiting to come back.
    t_in_item  pending[$];
    t_out_item expected_status[$];

    int  err_count     = 0;
    int  results_seen  = 0;
    int  cycle_count   = 0;
    int  send_gap      = 0;
    int  ready_gap     = 0;
    int  hold_left_rdy = 0;
    int  send_gap_odds = 0;
    int  ready_gap_odds = 0;
    bit  stall_req     = 1'b0;

    // Mirrors of the configuration registers.
    logic [14:0] interval_cfg;
    logic [15:0] idle_cfg;
    logic [7:0]  wait_cfg;
    logic [15:0] hold_cfg;

    // Predicted state of the block.
    t_mode       cur_mode;
    logic [15:0] secs_to_sample;
    logic        sample_pending;
    logic [15:0] idle_left;
    logic [7:0]  boot_left;
    logic [15:0] hold_left;
    logic        hold_on;
    logic        red_on;
    logic        green_on;
    logic        skip_gps;
    logic        sensor_wait;
    logic [7:0]  wait_left;
    logic [3:0]  err_cnt;

    always #6 clk = ~clk;

    logger_mode_and_sample_timer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Leaving eco mode restarts the sample countdown at the normal interval.
    function automatic void leave_to_standard();
        if (cur_mode == MODE_ECO) begin
            secs_to_sample = {1'b0, interval_cfg};
        end
        cur_mode = MODE_STD;
    endfunction

    function automatic t_out_item predict_status(t_in_item ev);
        t_out_item res;
        res = '0;
        case (t_op'(ev.op))
            OP_SEC_TICK: begin
                if (secs_to_sample != 16'd0) begin
                    secs_to_sample = secs_to_sample - 16'd1;
                    if (secs_to_sample == 16'd0) sample_pending = 1'b1;
                end
                if (cur_mode == MODE_CFG && idle_left != 16'd0) begin
                    idle_left = idle_left - 16'd1;
                    if (idle_left == 16'd0) leave_to_standard();
                end
                if (boot_left != 8'd0) boot_left = boot_left - 8'd1;
                if (sensor_wait) begin
                    if (wait_left != 8'd0) begin
                        wait_left = wait_left - 8'd1;
                    end else begin
                        sensor_wait = 1'b0;
                        if (err_cnt != ERR_MAX) err_cnt = err_cnt + 4'd1;
                    end
                end
            end
            OP_MS_TICK: begin
                if (hold_on) begin
                    if (hold_left <= HOLD_STEP) begin
                        // Red acts before green when both are held.
                        hold_left = hold_cfg;
                        if (ev.red_down) begin
                            if (cur_mode != MODE_MTN) cur_mode = MODE_MTN;
                            else leave_to_standard();
                        end
                        if (ev.green_down) begin
                            if (cur_mode != MODE_ECO) begin
                                cur_mode       = MODE_ECO;
                                secs_to_sample = {interval_cfg, 1'b0};
                            end else begin
                                leave_to_standard();
                            end
                        end
                    end else begin
                        hold_left = hold_left - HOLD_STEP;
                    end
                    if (boot_left != 8'd0 && ev.red_down) begin
                        cur_mode  = MODE_CFG;
                        idle_left = idle_cfg;
                    end
                end
            end
            OP_RED_EDGE: begin
                red_on = !red_on;
                hold_on = red_on;
                if (red_on) hold_left = hold_cfg;
            end
            OP_GREEN_EDGE: begin
                green_on = !green_on;
                hold_on = green_on;
                if (green_on) hold_left = hold_cfg;
            end
            OP_SAMPLE_DONE: begin
                if (sample_pending) begin
                    if (cur_mode == MODE_ECO) begin
                        res.read_gps = !skip_gps;
                        skip_gps     = !skip_gps;
                    end else begin
                        res.read_gps = 1'b1;
                    end
                    res.store_sample = (cur_mode != MODE_MTN);
                    err_cnt          = '0;
                    sample_pending   = 1'b0;
                    secs_to_sample   = (cur_mode == MODE_ECO) ? {interval_cfg, 1'b0}
                                                              : {1'b0, interval_cfg};
                end
            end
            OP_CFG_CMD: begin
                if (cur_mode == MODE_CFG) idle_left = idle_cfg;
            end
            OP_SENSOR_SILENT: begin
                if (!sensor_wait) begin
                    sensor_wait = 1'b1;
                    wait_left   = wait_cfg;
                end
            end
            OP_SENSOR_OK: begin
                sensor_wait = 1'b0;
                wait_left   = '0;
            end
        endcase
        res.mode_now       = cur_mode;
        res.sample_due     = sample_pending;
        res.sensor_waiting = sensor_wait;
        res.sensor_errors  = err_cnt;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at result %0d: %s got %0d, expected %0d",
                 results_seen, what, got, want);
        err_count++;
    endtask

    task automatic push_event(input t_op op, input logic red, input logic green);
        t_in_item ev;
        ev.op         = op;
        ev.red_down   = red;
        ev.green_down = green;
        pending.push_back(ev);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SAMPLE_INTERVAL: interval_cfg = val[14:0];
            CFG_IDLE_LIMIT:      idle_cfg     = val;
            CFG_WAIT_LIMIT:      wait_cfg     = val[7:0];
            CFG_HOLD_RELOAD:     hold_cfg     = val;
            CFG_STARTUP_WINDOW:  boot_left    = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] interval, input logic [15:0] idle,
                                  input logic [15:0] wait_lim, input logic [15:0] hold,
                                  input logic [15:0] window, input bit touch_unused);
        write_reg(CFG_SAMPLE_INTERVAL, interval);
        write_reg(CFG_IDLE_LIMIT, idle);
        write_reg(CFG_WAIT_LIMIT, wait_lim);
        write_reg(CFG_HOLD_RELOAD, hold);
        write_reg(CFG_STARTUP_WINDOW, window);
        // Writes to indexes past the last register must leave everything alone.
        if (touch_unused) begin
            for (int k = CFG_STARTUP_WINDOW + 1; k < (1 << CFG_IDX_W); k++) begin
                write_reg(k[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
            end
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sampled between edges so that the driver's and monitor's updates have settled.
    task automatic wait_drain();
        do @(negedge clk);
        while (pending.size() != 0 || in_valid || expected_status.size() != 0);
    endtask

    // Mostly well-formed button holds, sample cycles and sensor waits, plus noise.
    task automatic queue_events(input int count);
        int  start_sz;
        int  kind;
        int  reps;
        bit  use_red;
        t_op edge_op;
        start_sz = pending.size();
        while (pending.size() - start_sz < count) begin
            kind = $urandom_range(0, 19);
            if (kind < 6) begin
                use_red = 1'($urandom_range(0, 1));
                edge_op = use_red ? OP_RED_EDGE : OP_GREEN_EDGE;
                push_event(edge_op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                reps = $urandom_range(0, 6);
                repeat (reps) begin
                    if (use_red)
                        push_event(OP_MS_TICK, $urandom_range(0, 5) != 0,
                                   $urandom_range(0, 3) == 0);
                    else
                        push_event(OP_MS_TICK, $urandom_range(0, 3) == 0,
                                   $urandom_range(0, 5) != 0);
                end
                if ($urandom_range(0, 3) != 0)
                    push_event(edge_op, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
            end else if (kind < 10) begin
                reps = $urandom_range(1, 8);
                repeat (reps) push_event(OP_SEC_TICK, 1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) != 0)
                    push_event(OP_SAMPLE_DONE, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
            end else if (kind < 13) begin
                push_event(OP_SENSOR_SILENT, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                reps = $urandom_range(0, 5);
                repeat (reps) push_event(OP_SEC_TICK, 1'b0, 1'b0);
                if ($urandom_range(0, 1) != 0) push_event(OP_SENSOR_OK, 1'b0, 1'b1);
            end else if (kind < 15) begin
                push_event(OP_CFG_CMD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                reps = $urandom_range(1, 3);
                repeat (reps) push_event(OP_SEC_TICK, 1'b1, 1'b0);
            end else if (kind < 17) begin
                reps = $urandom_range(1, 4);
                repeat (reps) push_event(OP_MS_TICK, 1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)));
            end else begin
                reps = $urandom_range(1, 3);
                repeat (reps) push_event(t_op'($urandom_range(0, 7)),
                                         1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Sender: offers queued events and records the predicted status of each transaction.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_status.push_back(predict_status(in_item));
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    in_valid <= 1'b1;
                    in_item  <= pending.pop_front();
                    if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1)
                        send_gap = $urandom_range(1, 19);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stall bursts and, on request, one long hold-off.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_req) begin
            stall_req     = 1'b0;
            hold_left_rdy = LONG_HOLD;
            out_ready    <= 1'b0;
        end else if (hold_left_rdy != 0) begin
            hold_left_rdy--;
            out_ready <= 1'b0;
        end else if (ready_gap != 0) begin
            ready_gap--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (ready_gap_odds != 0 && $urandom_range(1, ready_gap_odds) == 1)
                ready_gap = $urandom_range(1, 19);
        end
    end

    // Monitor: compares each returned transaction with the oldest prediction.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_status.size() == 0) begin
                report_mismatch("unexpected transaction", o_out_data, 0);
            end else begin
                want = expected_status.pop_front();
                if (o_out_data.mode_now != want.mode_now)
                    report_mismatch("mode_now", o_out_data.mode_now, want.mode_now);
                if (o_out_data.sample_due != want.sample_due)
                    report_mismatch("sample_due", o_out_data.sample_due, want.sample_due);
                if (o_out_data.read_gps != want.read_gps)
                    report_mismatch("read_gps", o_out_data.read_gps, want.read_gps);
                if (o_out_data.store_sample != want.store_sample)
                    report_mismatch("store_sample", o_out_data.store_sample,
                                    want.store_sample);
                if (o_out_data.sensor_waiting != want.sensor_waiting)
                    report_mismatch("sensor_waiting", o_out_data.sensor_waiting,
                                    want.sensor_waiting);
                if (o_out_data.sensor_errors != want.sensor_errors)
                    report_mismatch("sensor_errors", o_out_data.sensor_errors,
                                    want.sensor_errors);
            end
            results_seen++;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_status.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int n_items;
        interval_cfg   = RST_SAMPLE_INTERVAL;
        idle_cfg       = RST_IDLE_LIMIT;
        wait_cfg       = RST_WAIT_LIMIT;
        hold_cfg       = RST_HOLD_RELOAD;
        cur_mode       = MODE_STD;
        secs_to_sample = {1'b0, RST_SAMPLE_INTERVAL};
        sample_pending = 1'b0;
        idle_left      = RST_IDLE_LIMIT;
        boot_left      = RST_STARTUP_WINDOW;
        hold_left      = RST_HOLD_RELOAD;
        hold_on        = 1'b0;
        red_on         = 1'b0;
        green_on       = 1'b0;
        skip_gps       = 1'b0;
        sensor_wait    = 1'b0;
        wait_left      = '0;
        err_cnt        = '0;
        send_gap_odds  = 5;
        ready_gap_odds = 5;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: ignored events, then red held inside the startup window.
        push_event(OP_SAMPLE_DONE, 1'b1, 1'b1);
        push_event(OP_CFG_CMD, 1'b0, 1'b0);
        push_event(OP_MS_TICK, 1'b1, 1'b1);
        push_event(OP_RED_EDGE, 1'b0, 1'b0);
        push_event(OP_MS_TICK, 1'b1, 1'b0);
        push_event(OP_CFG_CMD, 1'b0, 1'b1);
        push_event(OP_SENSOR_SILENT, 1'b0, 1'b0);
        push_event(OP_SENSOR_SILENT, 1'b1, 1'b0);
        push_event(OP_SEC_TICK, 1'b0, 1'b0);
        push_event(OP_SENSOR_OK, 1'b0, 1'b0);
        push_event(OP_RED_EDGE, 1'b1, 1'b1);
        push_event(OP_MS_TICK, 1'b1, 1'b0);
        wait_drain();

        // Shortest hold: both buttons expire together, a release disarms the
        // other button's hold, a zero sensor wait times out, a sample completes in eco.
        apply_settings(16'd1, 16'd2, 16'd0, 16'd4, 16'd0, 1'b0);
        push_event(OP_GREEN_EDGE, 1'b0, 1'b0);
        push_event(OP_MS_TICK, 1'b0, 1'b1);
        push_event(OP_RED_EDGE, 1'b0, 1'b0);
        push_event(OP_MS_TICK, 1'b1, 1'b1);
        push_event(OP_GREEN_EDGE, 1'b0, 1'b0);
        push_event(OP_MS_TICK, 1'b1, 1'b0);
        push_event(OP_SENSOR_SILENT, 1'b0, 1'b0);
        push_event(OP_SEC_TICK, 1'b0, 1'b0);
        push_event(OP_SEC_TICK, 1'b0, 1'b0);
        push_event(OP_SEC_TICK, 1'b0, 1'b0);
        push_event(OP_SAMPLE_DONE, 1'b0, 1'b0);
        push_event(OP_RED_EDGE, 1'b0, 1'b0);
        wait_drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    apply_settings(16'd3, 16'd4, 16'd2, 16'd8, 16'd40, 1'b0);
                    n_items = 170;
                    send_gap_odds  = 6;
                    ready_gap_odds = 6;
                end
                1: begin
                    // Top of every range but the hold reload; the interval write also has its unused bit set.
                    apply_settings(16'hFFFF, 16'd65535, 16'd255, 16'd65532, 16'd255, 1'b1);
                    n_items = 80;
                    send_gap_odds  = 0;
                    ready_gap_odds = 0;
                end
                2: begin
                    apply_settings(16'd1, 16'd1, 16'd0, 16'd4, 16'd0, 1'b0);
                    n_items = 130;
                    send_gap_odds  = 4;
                    ready_gap_odds = 10;
                    // Enough timeouts in a row to hit the error count ceiling.
                    repeat (17) begin
                        push_event(OP_SENSOR_SILENT, 1'b0, 1'b0);
                        push_event(OP_SEC_TICK, 1'b0, 1'b0);
                    end
                end
                default: begin
                    apply_settings(16'($urandom_range(1, 6)), 16'($urandom_range(1, 10)),
                                   16'($urandom_range(0, 5)), 16'($urandom_range(4, 24)),
                                   16'($urandom_range(0, 60)), 1'b0);
                    n_items = (ph == 5) ? 130 : 170;
                    send_gap_odds  = (ph == 5) ? 0 : $urandom_range(3, 12);
                    ready_gap_odds = (ph == 5) ? 0 : $urandom_range(3, 12);
                end
            endcase
            queue_events(n_items);
            // The receiver holds off while events keep coming, so the input backs up.
            if (ph == 0) stall_req = 1'b1;
            wait_drain();
        end

        repeat (4) @(posedge clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### logger_mode_and_sample_timer.f
sv/lmst_pkg.sv
sv/lmst_core.sv
sv/lmst_out_reg.sv
sv/logger_mode_and_sample_timer.sv
verif/logger_mode_and_sample_timer_tb.sv
